// ===== src/frb_pkg.sv =====
// shared types and constants for the fifo/lifo ring buffer
// used by frb_cell, frb_ctrl and fifo_lifo_ring_buffer_top; no dependencies
package frb_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CFG_IDX_W    = 2;
  localparam int STATUS_W     = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd2;

  // request commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd3;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0] pop_data;
    logic [STATUS_W-1:0]     status;
    logic                    is_empty;
    logic                    is_full;
    logic [CNT_W-1:0]        element_count;
  } result_t;

endpackage

// ===== src/frb_cell.sv =====
// one storage cell of the element chain; cell k holds the k-th newest element
// depends on frb_pkg
module frb_cell (
  input  logic                              clk_i,
  input  frb_pkg::cell_ctl_t                ctl_i,
  input  logic [frb_pkg::ELEMENT_BITS-1:0]  up_i,
  input  logic [frb_pkg::ELEMENT_BITS-1:0]  down_i,
  output logic [frb_pkg::ELEMENT_BITS-1:0]  data_o
);

  logic [frb_pkg::ELEMENT_BITS-1:0] data_q;
  logic [frb_pkg::ELEMENT_BITS-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      data_d = up_i;
    end else if (ctl_i.shift_down) begin
      data_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/frb_ctrl.sv =====
// occupancy counter, configuration registers and request decode
// depends on frb_pkg; drives the shift controls of the frb_cell chain
module frb_ctrl (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_valid_i,
  input  logic [frb_pkg::CFG_IDX_W-1:0]                      cfg_index_i,
  input  logic [frb_pkg::CNT_W-1:0]                          cfg_data_i,
  input  logic                                               req_i,
  input  logic                                               command_i,
  input  logic [frb_pkg::MAX_ELEMENTS-1:0][frb_pkg::ELEMENT_BITS-1:0] cells_i,
  output frb_pkg::cell_ctl_t                                 ctl_o,
  output frb_pkg::result_t                                   res_o
);

  logic [frb_pkg::CNT_W-1:0] count_q, count_d;
  logic [frb_pkg::CNT_W-1:0] cap_q;
  logic                      stack_q;
  logic                      ow_q;
  logic [frb_pkg::CNT_W-1:0] cap_eff;
  logic                      full;
  logic [frb_pkg::CNT_W-1:0] last_pos;
  logic [frb_pkg::IDX_W-1:0] oldest_idx;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = frb_pkg::CNT_W'(1);
    end else if (cap_q > frb_pkg::CNT_W'(frb_pkg::MAX_ELEMENTS)) begin
      cap_eff = frb_pkg::CNT_W'(frb_pkg::MAX_ELEMENTS);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full       = count_q >= cap_eff;
  assign last_pos   = count_q - frb_pkg::CNT_W'(1);
  assign oldest_idx = last_pos[frb_pkg::IDX_W-1:0];

  always_comb begin
    count_d            = count_q;
    ctl_o              = '0;
    res_o.pop_data     = '0;
    res_o.status       = frb_pkg::ST_OK;
    if (command_i == frb_pkg::CMD_PUSH) begin
      if (full && !ow_q) begin
        res_o.status = frb_pkg::ST_REJECT;
      end else begin
        // the chain shifts toward the old end; an overwritten element falls off
        ctl_o.shift_up = req_i;
        if (full) begin
          res_o.status = frb_pkg::ST_OVERWRITE;
        end else begin
          count_d = count_q + frb_pkg::CNT_W'(1);
        end
      end
    end else begin
      if (count_q == '0) begin
        res_o.status = frb_pkg::ST_EMPTY;
      end else if (stack_q) begin
        res_o.pop_data   = cells_i[0];
        ctl_o.shift_down = req_i;
        count_d          = last_pos;
      end else begin
        // oldest element sits at the far end of the occupied cells
        res_o.pop_data = cells_i[oldest_idx];
        count_d        = last_pos;
      end
    end
    res_o.element_count = count_d;
    res_o.is_empty      = count_d == '0;
    res_o.is_full       = count_d >= cap_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= frb_pkg::CNT_W'(frb_pkg::MAX_ELEMENTS);
      stack_q <= 1'b0;
      ow_q    <= 1'b0;
    end else begin
      if (req_i) begin
        count_q <= count_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          frb_pkg::CFG_CAPACITY:  cap_q   <= cfg_data_i;
          frb_pkg::CFG_STACK:     stack_q <= cfg_data_i[0];
          frb_pkg::CFG_OVERWRITE: ow_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/fifo_lifo_ring_buffer_top.sv =====
// top level of the fifo/lifo ring buffer: cell chain, control and output skid
// depends on frb_pkg, frb_cell and frb_ctrl

// Accepts one push or pop request per clock cycle while in_stall_o is low and
// returns exactly one result per request, registered in the output register
// or, behind a held output, in the skid stage. Elements live in a row of 16
// cells ordered newest first: a push shifts the whole row by one cell, a stack
// pop shifts it back, and a queue pop reads the oldest occupied cell.
// An output register plus a one-entry skid stage let a new request in while
// a result waits; in_stall_o rises only when both are full.
// Configuration writes are always ready and should only be made while idle.
module fifo_lifo_ring_buffer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [frb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [frb_pkg::CNT_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [frb_pkg::ELEMENT_BITS-1:0]    push_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [frb_pkg::ELEMENT_BITS-1:0]    pop_data_o,
  output logic [frb_pkg::STATUS_W-1:0]        status_o,
  output logic                                is_empty_o,
  output logic                                is_full_o,
  output logic [frb_pkg::CNT_W-1:0]           element_count_o
);

  logic [frb_pkg::MAX_ELEMENTS-1:0][frb_pkg::ELEMENT_BITS-1:0] cells;
  frb_pkg::cell_ctl_t ctl;
  frb_pkg::result_t   res;
  frb_pkg::result_t   out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               in_acc;
  logic               out_take;
  logic               out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || out_take;

  frb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_acc),
    .command_i   (command_i),
    .cells_i     (cells),
    .ctl_o       (ctl),
    .res_o       (res)
  );

  for (genvar k = 0; k < frb_pkg::MAX_ELEMENTS; k++) begin : g_cell
    logic [frb_pkg::ELEMENT_BITS-1:0] up_data;
    logic [frb_pkg::ELEMENT_BITS-1:0] down_data;
    if (k == 0) begin : g_first
      assign up_data = push_data_i;
    end else begin : g_mid
      assign up_data = cells[k-1];
    end
    if (k == frb_pkg::MAX_ELEMENTS - 1) begin : g_last
      assign down_data = '0;
    end else begin : g_inner
      assign down_data = cells[k+1];
    end
    frb_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .up_i   (up_data),
      .down_i (down_data),
      .data_o (cells[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pop_data_o      = out_q.pop_data;
  assign status_o        = out_q.status;
  assign is_empty_o      = out_q.is_empty;
  assign is_full_o       = out_q.is_full;
  assign element_count_o = out_q.element_count;

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_empty_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == frb_pkg::ST_EMPTY) |-> (pop_data_o == '0 && is_empty_o))
    else $error("pop on empty returned data or nonempty flag");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (element_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (element_count_o <= frb_pkg::CNT_W'(frb_pkg::MAX_ELEMENTS)))
    else $error("element count above store depth");

  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_valid_q) |=> out_valid_q)
    else $error("accepted request produced no result");

endmodule
